FILE: rtl/dwb_pkg.sv
package dwb_pkg;

  // Configuration register indexes, in write-port order.
  typedef enum logic [2:0] {
    REG_FOCAL_X          = 3'd0,
    REG_FOCAL_Y          = 3'd1,
    REG_CENTER_X         = 3'd2,
    REG_CENTER_Y         = 3'd3,
    REG_PIXEL_VAR_U      = 3'd4,
    REG_PIXEL_VAR_V      = 3'd5,
    REG_DEPTH_NOISE_GAIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] pixel_var_u;
    logic [15:0] pixel_var_v;
    logic [31:0] depth_noise_gain;
  } cfg_t;

  // Divider geometry: numerator, divisor and quotient widths.
  localparam int FRONT_N = 58;
  localparam int FRONT_D = 9;
  localparam int FRONT_Q = 53;
  localparam int BACK_N  = 89;
  localparam int BACK_D  = 40;
  localparam int BACK_Q  = 48;

  // Register stages in the window and projection sections.
  localparam int WIN_LAT  = 7;
  localparam int PROJ_LAT = 5;

  localparam logic [47:0] CAP48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] POS_CAP31 = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] POS_CAP47 = 48'h7FFF_FFFF_FFFF;
  localparam logic [52:0] NOISE_CAP = 53'h10_0000_0000_0000;

  // Pixel offsets from the principal point, as sign and magnitude.
  typedef struct packed {
    logic        pv;
    logic        nx;
    logic        ny;
    logic [15:0] ax;
    logic [15:0] ay;
  } side_t;

  // Window moments, ready for division by the weight sums.
  typedef struct packed {
    logic        valid;
    logic [57:0] mz_num;
    logic [57:0] ns_num;
    logic [57:0] sp_num;
    logic [8:0]  w_den;
    logic [8:0]  w2_den;
    side_t       side;
  } fr_t;

  // Fields that ride alongside the projection quotients.
  typedef struct packed {
    logic        pv;
    logic        nx;
    logic        ny;
    logic [23:0] mz;
    logic [47:0] vz;
  } btag_t;

  // Projection numerators and divisors.
  typedef struct packed {
    logic        valid;
    logic [39:0] num_x;
    logic [39:0] num_y;
    logic [63:0] num_xz;
    logic [63:0] num_yz;
    logic [79:0] num_xy;
    logic [88:0] num_xx;
    logic [88:0] num_yy;
    logic [15:0] den_x;
    logic [15:0] den_y;
    logic [39:0] den_xx;
    logic [39:0] den_yy;
    logic [31:0] den_xy;
    btag_t       tag;
  } proj_t;

  // Weight of a window cell: centre 4, cross 2, corner 1.
  function automatic logic [2:0] cell_weight(input int i);
    if (i == 4) begin
      return 3'd4;
    end else if ((i % 2) == 1) begin
      return 3'd2;
    end else begin
      return 3'd1;
    end
  endfunction

  // Clamps a quotient magnitude to a signed range and applies the sign.
  function automatic logic [47:0] sign_fit(input logic [47:0] q, input logic sat,
                                           input logic neg, input logic [47:0] poscap);
    logic [47:0] cap;
    logic [47:0] mag;
    cap = neg ? (poscap + 48'd1) : poscap;
    mag = (sat || (q > cap)) ? cap : q;
    return neg ? (~mag + 48'd1) : mag;
  endfunction

endpackage

FILE: rtl/dwb_div.sv
module dwb_div #(
  parameter int N     = 58,
  parameter int D     = 9,
  parameter int Q     = 53,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [N-1:0]     num,
  input  logic [D-1:0]     den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q-1:0]     quo,
  output logic             sat,
  output logic [TAG_W-1:0] out_tag
);

  localparam int HW = N + 1 - Q;
  localparam int CW = (HW > D) ? HW : D;

  logic             a_valid;
  logic [N:0]       a_nr;
  logic [D-1:0]     a_den;
  logic [TAG_W-1:0] a_tag;
  logic [CW-1:0]    hi_ext;

  logic             st_valid [Q+1];
  logic [D-1:0]     st_rem   [Q+1];
  logic [Q-1:0]     st_low   [Q+1];
  logic [Q-1:0]     st_quo   [Q+1];
  logic             st_sat   [Q+1];
  logic [D-1:0]     st_den   [Q+1];
  logic [TAG_W-1:0] st_tag   [Q+1];

  // Add half the divisor so that the floor quotient rounds to nearest.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_nr  <= (N+1)'(num) + (N+1)'(den >> 1);
    a_den <= den;
    a_tag <= in_tag;
  end

  // The quotient overflows exactly when the bits above it reach the divisor.
  assign hi_ext = CW'(a_nr[N:Q]);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= a_valid;
    end
    st_sat[0] <= hi_ext >= CW'(a_den);
    st_rem[0] <= (hi_ext >= CW'(a_den)) ? '0 : hi_ext[D-1:0];
    st_low[0] <= a_nr[Q-1:0];
    st_quo[0] <= '0;
    st_den[0] <= a_den;
    st_tag[0] <= a_tag;
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [D:0] trial;
    logic       take;

    assign trial = {st_rem[k], st_low[k][Q-1]};
    assign take  = trial >= {1'b0, st_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
      st_rem[k+1] <= take ? D'(trial - {1'b0, st_den[k]}) : trial[D-1:0];
      st_low[k+1] <= {st_low[k][Q-2:0], 1'b0};
      st_quo[k+1] <= {st_quo[k][Q-2:0], take};
      st_sat[k+1] <= st_sat[k];
      st_den[k+1] <= st_den[k];
      st_tag[k+1] <= st_tag[k];
    end
  end

  assign out_valid = st_valid[Q];
  assign quo       = st_quo[Q];
  assign sat       = st_sat[Q];
  assign out_tag   = st_tag[Q];

endmodule

FILE: rtl/dwb_window.sv
module dwb_window #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [9:0]    key_col,
  input  logic [8:0]    key_row,
  input  logic [15:0]   depth [9],
  input  dwb_pkg::cfg_t cfg,
  output dwb_pkg::fr_t  fr
);
  import dwb_pkg::*;

  logic [12:0] col_e;
  logic [12:0] row_e;
  logic [2:0]  col_ok;
  logic [2:0]  row_ok;
  logic [16:0] du;
  logic [16:0] dv;

  logic        vld [WIN_LAT-1];
  side_t       sd  [WIN_LAT-1];

  logic [15:0] r0_z [9];
  logic [2:0]  r0_w [9];

  logic [31:0] r1_z2 [9];
  logic [2:0]  r1_w  [9];
  logic [4:0]  r1_wsum;
  logic [19:0] r1_s1;

  logic [63:0] r2_t [9];
  logic [2:0]  r2_w [9];
  logic [4:0]  r2_wsum;
  logic [19:0] r2_s1;
  logic [36:0] r2_s2;

  logic [53:0] r3_hh  [9];
  logic [53:0] r3_hl  [9];
  logic [53:0] r3_ll  [9];
  logic        r3_sat [9];
  logic [2:0]  r3_w   [9];
  logic [4:0]  r3_wsum;
  logic [19:0] r3_s1;
  logic [36:0] r3_s2;

  logic [52:0] r4_n [9];
  logic [2:0]  r4_w [9];
  logic [4:0]  r4_wsum;
  logic [19:0] r4_s1;
  logic [36:0] r4_s2;

  logic [56:0] r5_ns;
  logic [41:0] r5_ws2;
  logic [39:0] r5_s1sq;
  logic [4:0]  r5_wsum;
  logic [19:0] r5_s1;

  logic [4:0]  wsum_c;
  logic [19:0] s1_c;
  logic [36:0] s2_c;
  logic [56:0] ns_c;

  // Border tests for the three columns and rows of the window.
  assign col_e = {3'b000, key_col};
  assign row_e = {4'b0000, key_row};
  assign col_ok[0] = (key_col != 10'd0) && (col_e <= 13'(IMAGE_WIDTH));
  assign col_ok[1] = col_e <= 13'(IMAGE_WIDTH - 1);
  assign col_ok[2] = col_e <= 13'(IMAGE_WIDTH - 2);
  assign row_ok[0] = (key_row != 9'd0) && (row_e <= 13'(IMAGE_HEIGHT));
  assign row_ok[1] = row_e <= 13'(IMAGE_HEIGHT - 1);
  assign row_ok[2] = row_e <= 13'(IMAGE_HEIGHT - 2);

  assign du = {3'b000, key_col, 4'b0000} - {1'b0, cfg.center_x};
  assign dv = {4'b0000, key_row, 4'b0000} - {1'b0, cfg.center_y};

  // Valid bits and pixel offsets travel with the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < WIN_LAT - 1; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < WIN_LAT - 1; s++) begin
        vld[s] <= vld[s-1];
      end
    end
    sd[0].pv <= 1'b0;
    sd[0].nx <= du[16];
    sd[0].ny <= dv[16];
    sd[0].ax <= du[16] ? 16'(~du + 17'd1) : du[15:0];
    sd[0].ay <= dv[16] ? 16'(~dv + 17'd1) : dv[15:0];
    for (int s = 1; s < WIN_LAT - 1; s++) begin
      sd[s] <= sd[s-1];
    end
  end

  // Cells outside the image or without depth get weight and depth zero.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      if (col_ok[i % 3] && row_ok[i / 3] && (depth[i] != 16'd0)) begin
        r0_z[i] <= depth[i];
        r0_w[i] <= cell_weight(i);
      end else begin
        r0_z[i] <= 16'd0;
        r0_w[i] <= 3'd0;
      end
    end
  end

  // Squared depths, weight sum and first moment.
  always_comb begin
    wsum_c = '0;
    s1_c   = '0;
    for (int i = 0; i < 9; i++) begin
      wsum_c = wsum_c + 5'(r0_w[i]);
      s1_c   = s1_c + 20'(r0_w[i]) * 20'(r0_z[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      r1_z2[i] <= 32'(r0_z[i]) * 32'(r0_z[i]);
      r1_w[i]  <= r0_w[i];
    end
    r1_wsum <= wsum_c;
    r1_s1   <= s1_c;
  end

  // Noise root k_z z^2 per cell and the second moment.
  always_comb begin
    s2_c = '0;
    for (int i = 0; i < 9; i++) begin
      s2_c = s2_c + 37'(r1_w[i]) * 37'(r1_z2[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      r2_t[i] <= 64'(cfg.depth_noise_gain) * 64'(r1_z2[i]);
      r2_w[i] <= r1_w[i];
    end
    r2_wsum <= r1_wsum;
    r2_s1   <= r1_s1;
    r2_s2   <= s2_c;
  end

  // Square of the noise root, as three partial products of halves.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      r3_hh[i]  <= 54'(r2_t[i][53:27]) * 54'(r2_t[i][53:27]);
      r3_hl[i]  <= 54'(r2_t[i][53:27]) * 54'(r2_t[i][26:0]);
      r3_ll[i]  <= 54'(r2_t[i][26:0]) * 54'(r2_t[i][26:0]);
      r3_sat[i] <= r2_t[i][63:54] != 10'd0;
      r3_w[i]   <= r2_w[i];
    end
    r3_wsum <= r2_wsum;
    r3_s1   <= r2_s1;
    r3_s2   <= r2_s2;
  end

  // Per-cell noise, capped where the square would pass the limit.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      logic [107:0] sq;
      sq = (108'(r3_hh[i]) << 54) + (108'(r3_hl[i]) << 28) + 108'(r3_ll[i]);
      r4_n[i] <= r3_sat[i] ? NOISE_CAP : {1'b0, sq[107:56]};
      r4_w[i] <= r3_w[i];
    end
    r4_wsum <= r3_wsum;
    r4_s1   <= r3_s1;
    r4_s2   <= r3_s2;
  end

  // Weighted noise sum and the spread terms.
  always_comb begin
    ns_c = '0;
    for (int i = 0; i < 9; i++) begin
      ns_c = ns_c + 57'(r4_w[i]) * 57'(r4_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    r5_ns   <= ns_c;
    r5_ws2  <= 42'(r4_wsum) * 42'(r4_s2);
    r5_s1sq <= 40'(r4_s1) * 40'(r4_s1);
    r5_wsum <= r4_wsum;
    r5_s1   <= r4_s1;
  end

  // Numerators and divisors; an empty window divides by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr.valid <= 1'b0;
    end else begin
      fr.valid <= vld[WIN_LAT-2];
    end
    fr.mz_num  <= 58'(r5_s1) << 8;
    fr.ns_num  <= 58'(r5_ns);
    fr.sp_num  <= 58'(r5_ws2 - 42'(r5_s1sq)) << 8;
    fr.w_den   <= (r5_wsum == 5'd0) ? 9'd1 : 9'(r5_wsum);
    fr.w2_den  <= (r5_wsum == 5'd0) ? 9'd1 : 9'(r5_wsum) * 9'(r5_wsum);
    fr.side.pv <= r5_wsum != 5'd0;
    fr.side.nx <= sd[WIN_LAT-2].nx;
    fr.side.ny <= sd[WIN_LAT-2].ny;
    fr.side.ax <= sd[WIN_LAT-2].ax;
    fr.side.ay <= sd[WIN_LAT-2].ay;
  end

endmodule

FILE: rtl/dwb_project.sv
module dwb_project (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [23:0]    mz_in,
  input  logic [52:0]    noise,
  input  logic [52:0]    spread,
  input  dwb_pkg::side_t side,
  input  dwb_pkg::cfg_t  cfg,
  output dwb_pkg::proj_t out
);
  import dwb_pkg::*;

  logic [53:0] vz_sum;

  logic        p0_valid;
  side_t       p0_side;
  logic [23:0] p0_mz;
  logic [47:0] p0_vz;
  logic [15:0] p0_fx;
  logic [15:0] p0_fy;

  logic        p1_valid;
  side_t       p1_side;
  logic [23:0] p1_mz;
  logic [47:0] p1_vz;
  logic [39:0] p1_a;
  logic [39:0] p1_b;
  logic [63:0] p1_c;
  logic [63:0] p1_d;
  logic [47:0] p1_mz2;
  logic [15:0] p1_fx;
  logic [15:0] p1_fy;
  logic [31:0] p1_fx2;
  logic [31:0] p1_fy2;
  logic [31:0] p1_fxy;

  logic        p2_valid;
  side_t       p2_side;
  logic [23:0] p2_mz;
  logic [47:0] p2_vz;
  logic [39:0] p2_a;
  logic [39:0] p2_b;
  logic [63:0] p2_c;
  logic [63:0] p2_d;
  logic [79:0] p2_e;
  logic [79:0] p2_f;
  logic [79:0] p2_g;
  logic [56:0] p2_h;
  logic [15:0] p2_fx;
  logic [15:0] p2_fy;
  logic [31:0] p2_fx2;
  logic [31:0] p2_fy2;
  logic [31:0] p2_fxy;

  logic        p3_valid;
  side_t       p3_side;
  logic [23:0] p3_mz;
  logic [47:0] p3_vz;
  logic [39:0] p3_a;
  logic [39:0] p3_b;
  logic [63:0] p3_c;
  logic [63:0] p3_d;
  logic [79:0] p3_e;
  logic [79:0] p3_f;
  logic [79:0] p3_g;
  logic [72:0] p3_pu;
  logic [72:0] p3_pv;
  logic [15:0] p3_fx;
  logic [15:0] p3_fy;
  logic [31:0] p3_fx2;
  logic [31:0] p3_fy2;
  logic [31:0] p3_fxy;

  assign vz_sum = 54'(noise) + 54'(spread);

  // Saturated depth variance and focal lengths with zero read as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= in_valid;
    end
    p0_side <= side;
    p0_mz   <= mz_in;
    p0_vz   <= (vz_sum > 54'(CAP48)) ? CAP48 : vz_sum[47:0];
    p0_fx   <= (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
    p0_fy   <= (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;
  end

  // First products with the pixel offsets and the focal squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= p0_valid;
    end
    p1_side <= p0_side;
    p1_mz   <= p0_mz;
    p1_vz   <= p0_vz;
    p1_a    <= 40'(p0_mz) * 40'(p0_side.ax);
    p1_b    <= 40'(p0_mz) * 40'(p0_side.ay);
    p1_c    <= 64'(p0_vz) * 64'(p0_side.ax);
    p1_d    <= 64'(p0_vz) * 64'(p0_side.ay);
    p1_mz2  <= 48'(p0_mz) * 48'(p0_mz);
    p1_fx   <= p0_fx;
    p1_fy   <= p0_fy;
    p1_fx2  <= 32'(p0_fx) * 32'(p0_fx);
    p1_fy2  <= 32'(p0_fy) * 32'(p0_fy);
    p1_fxy  <= 32'(p0_fx) * 32'(p0_fy);
  end

  // Second products and the term scaled by the pixel noise.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_side <= p1_side;
    p2_mz   <= p1_mz;
    p2_vz   <= p1_vz;
    p2_a    <= p1_a;
    p2_b    <= p1_b;
    p2_c    <= p1_c;
    p2_d    <= p1_d;
    p2_e    <= 80'(p1_c) * 80'(p1_side.ax);
    p2_f    <= 80'(p1_d) * 80'(p1_side.ay);
    p2_g    <= 80'(p1_c) * 80'(p1_side.ay);
    p2_h    <= 57'(p1_mz2) + {1'b0, p1_vz, 8'h00};
    p2_fx   <= p1_fx;
    p2_fy   <= p1_fy;
    p2_fx2  <= p1_fx2;
    p2_fy2  <= p1_fy2;
    p2_fxy  <= p1_fxy;
  end

  // Pixel noise contribution to the lateral variances.
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_side <= p2_side;
    p3_mz   <= p2_mz;
    p3_vz   <= p2_vz;
    p3_a    <= p2_a;
    p3_b    <= p2_b;
    p3_c    <= p2_c;
    p3_d    <= p2_d;
    p3_e    <= p2_e;
    p3_f    <= p2_f;
    p3_g    <= p2_g;
    p3_pu   <= 73'(cfg.pixel_var_u) * 73'(p2_h);
    p3_pv   <= 73'(cfg.pixel_var_v) * 73'(p2_h);
    p3_fx   <= p2_fx;
    p3_fy   <= p2_fy;
    p3_fx2  <= p2_fx2;
    p3_fy2  <= p2_fy2;
    p3_fxy  <= p2_fxy;
  end

  // Final numerators and divisors for the quotient pipelines.
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= p3_valid;
    end
    out.num_x  <= p3_a;
    out.num_y  <= p3_b;
    out.num_xz <= p3_c;
    out.num_yz <= p3_d;
    out.num_xy <= p3_g;
    out.num_xx <= (89'(p3_e) << 8) + 89'(p3_pu);
    out.num_yy <= (89'(p3_f) << 8) + 89'(p3_pv);
    out.den_x  <= p3_fx;
    out.den_y  <= p3_fy;
    out.den_xx <= {p3_fx2, 8'h00};
    out.den_yy <= {p3_fy2, 8'h00};
    out.den_xy <= p3_fxy;
    out.tag.pv <= p3_side.pv;
    out.tag.nx <= p3_side.nx;
    out.tag.ny <= p3_side.ny;
    out.tag.mz <= p3_mz;
    out.tag.vz <= p3_vz;
  end

endmodule

FILE: rtl/depth_window_backprojection.sv
// Channel   Handshake           Payload
// keypoint  start / busy        key_col, key_row, depth_nw .. depth_se
// config    cfg_we              cfg_index, cfg_data
// result    done (one cycle)    point_valid, point_x/y/z, cov_xx .. cov_yz
//
// One keypoint is taken in every cycle while busy is low. Most of the pipeline
// depth lies in the two chains of restoring quotient stages (53 and 48 stages),
// one quotient bit per stage, behind the window and projection multipliers.
// Reset clears the valid bits and loads the register defaults; busy is high
// only during reset. Results cannot be held off, so the pipeline never stops.
module depth_window_backprojection #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         key_col,
  input  logic [8:0]         key_row,
  input  logic [15:0]        depth_nw,
  input  logic [15:0]        depth_n,
  input  logic [15:0]        depth_ne,
  input  logic [15:0]        depth_w,
  input  logic [15:0]        depth_c,
  input  logic [15:0]        depth_e,
  input  logic [15:0]        depth_sw,
  input  logic [15:0]        depth_s,
  input  logic [15:0]        depth_se,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic               point_valid,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [23:0]        point_z,
  output logic [47:0]        cov_xx,
  output logic [47:0]        cov_yy,
  output logic [47:0]        cov_zz,
  output logic signed [47:0] cov_xy,
  output logic signed [47:0] cov_xz,
  output logic signed [47:0] cov_yz
);
  import dwb_pkg::*;

  localparam int LAT = WIN_LAT + FRONT_Q + 2 + PROJ_LAT + BACK_Q + 2 + 1;

  cfg_t        cfg;
  logic [15:0] depth [9];
  fr_t         fr;
  proj_t       pj;

  logic        mz_valid;
  logic [52:0] mz_q;
  logic [52:0] ns_q;
  logic [52:0] sp_q;
  side_t       mz_tag;

  logic        bx_valid;
  logic [47:0] qx, qy, qxx, qyy, qxy, qxz, qyz;
  logic        sx, sy, sxx, syy, sxy, sxz, syz;
  btag_t       bt;
  logic [47:0] fx_m, fy_m, fxy_m, fxz_m, fyz_m;

  assign busy = rst;

  assign depth[0] = depth_nw;
  assign depth[1] = depth_n;
  assign depth[2] = depth_ne;
  assign depth[3] = depth_w;
  assign depth[4] = depth_c;
  assign depth[5] = depth_e;
  assign depth[6] = depth_sw;
  assign depth[7] = depth_s;
  assign depth[8] = depth_se;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x          <= 16'd8400;
      cfg.focal_y          <= 16'd8400;
      cfg.center_x         <= 16'd5120;
      cfg.center_y         <= 16'd3840;
      cfg.pixel_var_u      <= 16'd256;
      cfg.pixel_var_v      <= 16'd256;
      cfg.depth_noise_gain <= 32'd5154;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X:          cfg.focal_x          <= cfg_data[15:0];
        REG_FOCAL_Y:          cfg.focal_y          <= cfg_data[15:0];
        REG_CENTER_X:         cfg.center_x         <= cfg_data[15:0];
        REG_CENTER_Y:         cfg.center_y         <= cfg_data[15:0];
        REG_PIXEL_VAR_U:      cfg.pixel_var_u      <= cfg_data[15:0];
        REG_PIXEL_VAR_V:      cfg.pixel_var_v      <= cfg_data[15:0];
        REG_DEPTH_NOISE_GAIN: cfg.depth_noise_gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dwb_window #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start && !busy),
    .key_col (key_col),
    .key_row (key_row),
    .depth   (depth),
    .cfg     (cfg),
    .fr      (fr)
  );

  // Mean depth, mean noise and depth spread over the window weights.
  dwb_div #(.N(FRONT_N), .D(FRONT_D), .Q(FRONT_Q), .TAG_W($bits(side_t))) u_div_mz (
    .clk(clk), .rst(rst), .in_valid(fr.valid), .num(fr.mz_num), .den(fr.w_den),
    .in_tag(fr.side), .out_valid(mz_valid), .quo(mz_q), .sat(), .out_tag(mz_tag)
  );

  dwb_div #(.N(FRONT_N), .D(FRONT_D), .Q(FRONT_Q), .TAG_W(1)) u_div_ns (
    .clk(clk), .rst(rst), .in_valid(fr.valid), .num(fr.ns_num), .den(fr.w_den),
    .in_tag(1'b0), .out_valid(), .quo(ns_q), .sat(), .out_tag()
  );

  dwb_div #(.N(FRONT_N), .D(FRONT_D), .Q(FRONT_Q), .TAG_W(1)) u_div_sp (
    .clk(clk), .rst(rst), .in_valid(fr.valid), .num(fr.sp_num), .den(fr.w2_den),
    .in_tag(1'b0), .out_valid(), .quo(sp_q), .sat(), .out_tag()
  );

  dwb_project u_project (
    .clk     (clk),
    .rst     (rst),
    .in_valid(mz_valid),
    .mz_in   (mz_q[23:0]),
    .noise   (ns_q),
    .spread  (sp_q),
    .side    (mz_tag),
    .cfg     (cfg),
    .out     (pj)
  );

  // Back-projection quotients, all of equal latency.
  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W($bits(btag_t))) u_div_x (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(BACK_N'(pj.num_x)),
    .den(BACK_D'(pj.den_x)), .in_tag(pj.tag), .out_valid(bx_valid), .quo(qx),
    .sat(sx), .out_tag(bt)
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(BACK_N'(pj.num_y)),
    .den(BACK_D'(pj.den_y)), .in_tag(1'b0), .out_valid(), .quo(qy), .sat(sy),
    .out_tag()
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_xx (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(pj.num_xx), .den(pj.den_xx),
    .in_tag(1'b0), .out_valid(), .quo(qxx), .sat(sxx), .out_tag()
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_yy (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(pj.num_yy), .den(pj.den_yy),
    .in_tag(1'b0), .out_valid(), .quo(qyy), .sat(syy), .out_tag()
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_xy (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(BACK_N'(pj.num_xy)),
    .den(BACK_D'(pj.den_xy)), .in_tag(1'b0), .out_valid(), .quo(qxy), .sat(sxy),
    .out_tag()
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_xz (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(BACK_N'(pj.num_xz)),
    .den(BACK_D'(pj.den_x)), .in_tag(1'b0), .out_valid(), .quo(qxz), .sat(sxz),
    .out_tag()
  );

  dwb_div #(.N(BACK_N), .D(BACK_D), .Q(BACK_Q), .TAG_W(1)) u_div_yz (
    .clk(clk), .rst(rst), .in_valid(pj.valid), .num(BACK_N'(pj.num_yz)),
    .den(BACK_D'(pj.den_y)), .in_tag(1'b0), .out_valid(), .quo(qyz), .sat(syz),
    .out_tag()
  );

  // Signed fields are clamped to their range before the sign is applied.
  assign fx_m  = sign_fit(qx, sx, bt.nx, POS_CAP31);
  assign fy_m  = sign_fit(qy, sy, bt.ny, POS_CAP31);
  assign fxy_m = sign_fit(qxy, sxy, bt.nx ^ bt.ny, POS_CAP47);
  assign fxz_m = sign_fit(qxz, sxz, bt.nx, POS_CAP47);
  assign fyz_m = sign_fit(qyz, syz, bt.ny, POS_CAP47);

  // Result register; an empty window gives an all-zero item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bx_valid;
    end
    point_valid <= bt.pv;
    point_x     <= bt.pv ? signed'(fx_m[31:0]) : '0;
    point_y     <= bt.pv ? signed'(fy_m[31:0]) : '0;
    point_z     <= bt.pv ? bt.mz : '0;
    cov_xx      <= bt.pv ? (sxx ? CAP48 : qxx) : '0;
    cov_yy      <= bt.pv ? (syy ? CAP48 : qyy) : '0;
    cov_zz      <= bt.pv ? bt.vz : '0;
    cov_xy      <= bt.pv ? signed'(fxy_m) : '0;
    cov_xz      <= bt.pv ? signed'(fxz_m) : '0;
    cov_yz      <= bt.pv ? signed'(fyz_m) : '0;
  end

`ifndef ASSERT_OFF
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a keypoint taken at the pipeline latency");

  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("keypoint taken but no result after the pipeline latency");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !point_valid) |-> (point_z == 24'd0 && cov_zz == 48'd0 && cov_xx == 48'd0))
    else $error("empty window gave a nonzero result");
`endif

endmodule
